### rtl/opl_pkg.sv
// Shared types, constants and coefficient tables for the oxygen percent
// linearizer with moving average. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package opl_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int HUND_W   = 12;
  localparam logic [HUND_W-1:0] HUND_MAX = HUND_W'(2100);

  // Fixed point, 24 fraction bits
  localparam int FRAC_W = 24;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int K_W    = 19;
  localparam int X_W    = 32;
  localparam int ACC_W  = 33;
  localparam int PROD_W = ACC_W + X_W;
  localparam int TOP_W  = 29;

  localparam logic signed [K_W-1:0]   SCALE_K   = K_W'(158005);
  localparam logic signed [X_W-1:0]   OFFSET_C0 = X_W'(9400675);
  localparam logic signed [X_W-1:0]   LOW_EDGE  = X_W'(12918456);
  localparam logic signed [X_W-1:0]   TOP_X     = X_W'(352321536);
  localparam logic signed [ACC_W-1:0] TOP_ACC   = ACC_W'(352321536);
  localparam logic [TOP_W-1:0]        TOP_Y     = TOP_W'(352321536);
  localparam logic [6:0]              PCT_SCALE = 7'd100;

  localparam logic [SAMPLE_W-1:0] REF_RESET = SAMPLE_W'(1226);

  // Horner step indexes
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_FIRST   = STEP_W'(1);
  localparam logic [STEP_W-1:0] CUBIC_LAST   = STEP_W'(3);
  localparam logic [STEP_W-1:0] QUARTIC_LAST = STEP_W'(4);

  // Averaging ring
  localparam int AVG_DEPTH  = 15;
  localparam int SLOT_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W      = $clog2(AVG_DEPTH * 2100 + 1);
  localparam int DIV_SHIFT  = SUM_W + SLOT_W;
  localparam int RECIP_W    = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((2 ** DIV_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);

  typedef enum logic [2:0] {
    LIN_IDLE,
    LIN_SCALE,
    LIN_REGION,
    LIN_HORNER,
    LIN_FINISH,
    LIN_HOLD
  } lin_state_e;

  typedef enum logic [1:0] {
    RING_IDLE,
    RING_UPDATE,
    RING_MEAN
  } ring_state_e;

  // Linearized word handed from the linearizer to the ring
  typedef struct packed {
    logic              valid;
    logic [HUND_W-1:0] hundredths;
  } lin_word_t;

  typedef logic signed [ACC_W-1:0] coef_t;

  // Cubic for the low region, highest power first
  function automatic coef_t cubic_coef(logic [STEP_W-1:0] idx);
    coef_t c;
    unique case (idx)
      3'd0:    c = ACC_W'(-141415154);
      3'd1:    c = ACC_W'(196461199);
      3'd2:    c = ACC_W'(-31625052);
      3'd3:    c = ACC_W'(2749786);
      default: c = '0;
    endcase
    return c;
  endfunction

  // Quartic for the main region, highest power first
  function automatic coef_t quartic_coef(logic [STEP_W-1:0] idx);
    coef_t c;
    unique case (idx)
      3'd0:    c = ACC_W'(2965);
      3'd1:    c = ACC_W'(-133010);
      3'd2:    c = ACC_W'(1813617);
      3'd3:    c = ACC_W'(9641866);
      3'd4:    c = ACC_W'(23907533);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/opl_sample_if.sv
// Input channel carrying one converter sample word with valid/ready.
// Depends on opl_pkg for the field width.
`timescale 1ns / 1ps

interface opl_sample_if;
  logic                         valid;
  logic                         ready;
  logic [opl_pkg::SAMPLE_W-1:0] lambda_sample;

  modport source (output valid, output lambda_sample, input ready);
  modport sink   (input valid, input lambda_sample, output ready);
endinterface

### rtl/opl_result_if.sv
// Output channel carrying one averaged oxygen word with valid/ready.
// Depends on opl_pkg for the field width.
`timescale 1ns / 1ps

interface opl_result_if;
  logic                       valid;
  logic                       ready;
  logic [opl_pkg::HUND_W-1:0] oxygen_hundredths;

  modport source (output valid, output oxygen_hundredths, input ready);
  modport sink   (input valid, input oxygen_hundredths, output ready);
endinterface

### rtl/oxygen_percent_linearizer_avg.sv
// Top level of the oxygen percent linearizer with moving average.
// Depends on opl_pkg, opl_sample_if, opl_result_if, opl_linearizer, opl_avg_ring.
`timescale 1ns / 1ps

// One sample word is taken at a time. Before it takes the next one, the
// linearizer runs scale, region select, Horner iterations (cubic or quartic
// region only), finish and a hold that waits for the ring. The Horner
// iterations run one per cycle on the single shared multiplier. The ring
// stage (memory read, write-back, mean) runs behind the linearizer, with the
// mean held in an output register so the next sample is accepted while a
// result waits. The ring is cleared by per-entry fill bits at reset, so no
// clearing pass is needed. lambda_reference resets to 1226; the user writes
// it through cfg_we_i / cfg_data_i only while the block idles; not enforced.

module oxygen_percent_linearizer_avg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  opl_sample_if.sink                   sample_i,
  opl_result_if.source                 result_o,
  input  logic                         cfg_we_i,
  input  logic [opl_pkg::SAMPLE_W-1:0] cfg_data_i
);

  logic [opl_pkg::SAMPLE_W-1:0] lambda_reference_q;
  opl_pkg::lin_word_t           lin_word;
  logic                         ring_ready;

  // Hold the reference sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_reference_q <= opl_pkg::REF_RESET;
    end else if (cfg_we_i) begin
      lambda_reference_q <= cfg_data_i;
    end
  end

  opl_linearizer u_lin (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sample_valid_i     (sample_i.valid),
    .sample_ready_o     (sample_i.ready),
    .lambda_sample_i    (sample_i.lambda_sample),
    .lambda_reference_i (lambda_reference_q),
    .lin_o              (lin_word),
    .ring_ready_i       (ring_ready)
  );

  opl_avg_ring u_ring (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .lin_i               (lin_word),
    .ring_ready_o        (ring_ready),
    .result_valid_o      (result_o.valid),
    .result_ready_i      (result_o.ready),
    .oxygen_hundredths_o (result_o.oxygen_hundredths)
  );

endmodule

### rtl/opl_linearizer.sv
// Sample-to-percent datapath: offset, linear scale, region select and
// Horner evaluation on one shared multiplier. Depends on opl_pkg.
`timescale 1ns / 1ps

module opl_linearizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic [opl_pkg::SAMPLE_W-1:0] lambda_sample_i,
  input  logic [opl_pkg::SAMPLE_W-1:0] lambda_reference_i,
  output opl_pkg::lin_word_t           lin_o,
  input  logic                         ring_ready_i
);

  opl_pkg::lin_state_e state_q, state_d;

  logic signed [opl_pkg::DIFF_W-1:0]  diff_q;
  logic signed [opl_pkg::X_W-1:0]     x_q;
  logic signed [opl_pkg::ACC_W-1:0]   acc_q;
  logic [opl_pkg::STEP_W-1:0]         step_q;
  logic                               quartic_q;
  logic [opl_pkg::HUND_W-1:0]         hund_q;

  logic signed [opl_pkg::X_W-1:0]     x_d;
  logic signed [opl_pkg::PROD_W-1:0]  hprod;
  logic signed [opl_pkg::PROD_W-1:0]  hshift;
  logic signed [opl_pkg::ACC_W-1:0]   acc_step;
  opl_pkg::coef_t                     coef;
  logic [opl_pkg::STEP_W-1:0]         step_last;
  logic [opl_pkg::TOP_W-1:0]          y_clamp;
  logic [opl_pkg::TOP_W+6:0]          y_pct;
  logic                               accept;

  assign accept = sample_valid_i && sample_ready_o;

  // Scale the difference to raw percent
  assign x_d = diff_q * opl_pkg::SCALE_K + opl_pkg::OFFSET_C0;

  // One Horner step: floored Q24 product plus next coefficient
  assign coef      = quartic_q ? opl_pkg::quartic_coef(step_q) : opl_pkg::cubic_coef(step_q);
  assign step_last = quartic_q ? opl_pkg::QUARTIC_LAST : opl_pkg::CUBIC_LAST;
  assign hprod     = acc_q * x_q;
  assign hshift    = hprod >>> opl_pkg::FRAC_W;
  assign acc_step  = $signed(hshift[opl_pkg::ACC_W-1:0]) + coef;

  // Clamp to 0..21 percent and convert to hundredths
  always_comb begin
    if (acc_q < 0) begin
      y_clamp = '0;
    end else if (acc_q > opl_pkg::TOP_ACC) begin
      y_clamp = opl_pkg::TOP_Y;
    end else begin
      y_clamp = acc_q[opl_pkg::TOP_W-1:0];
    end
  end
  assign y_pct = y_clamp * opl_pkg::PCT_SCALE;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      opl_pkg::LIN_IDLE: begin
        if (sample_valid_i) state_d = opl_pkg::LIN_SCALE;
      end
      opl_pkg::LIN_SCALE:  state_d = opl_pkg::LIN_REGION;
      opl_pkg::LIN_REGION: begin
        if (x_q < 0 || x_q >= opl_pkg::TOP_X) begin
          state_d = opl_pkg::LIN_FINISH;
        end else begin
          state_d = opl_pkg::LIN_HORNER;
        end
      end
      opl_pkg::LIN_HORNER: begin
        if (step_q == step_last) state_d = opl_pkg::LIN_FINISH;
      end
      opl_pkg::LIN_FINISH: state_d = opl_pkg::LIN_HOLD;
      opl_pkg::LIN_HOLD: begin
        if (ring_ready_i) state_d = opl_pkg::LIN_IDLE;
      end
      default: state_d = opl_pkg::LIN_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    sample_ready_o   = (state_q == opl_pkg::LIN_IDLE);
    lin_o.valid      = (state_q == opl_pkg::LIN_HOLD);
    lin_o.hundredths = hund_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= opl_pkg::LIN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q <= $signed({1'b0, lambda_sample_i}) - $signed({1'b0, lambda_reference_i});
    end
    unique case (state_q)
      opl_pkg::LIN_SCALE: x_q <= x_d;
      opl_pkg::LIN_REGION: begin
        step_q    <= opl_pkg::STEP_FIRST;
        quartic_q <= (x_q >= opl_pkg::LOW_EDGE);
        if (x_q < 0) begin
          acc_q <= '0;
        end else if (x_q < opl_pkg::LOW_EDGE) begin
          acc_q <= opl_pkg::cubic_coef('0);
        end else if (x_q < opl_pkg::TOP_X) begin
          acc_q <= opl_pkg::quartic_coef('0);
        end else begin
          acc_q <= opl_pkg::TOP_ACC;
        end
      end
      opl_pkg::LIN_HORNER: begin
        acc_q  <= acc_step;
        step_q <= step_q + 1'b1;
      end
      opl_pkg::LIN_FINISH: hund_q <= y_pct[opl_pkg::FRAC_W +: opl_pkg::HUND_W];
      default: ;
    endcase
  end

endmodule

### rtl/opl_avg_ring.sv
// History ring memory with running sum and mean by reciprocal multiply,
// ending in the output register. Depends on opl_pkg.
`timescale 1ns / 1ps

module opl_avg_ring (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  opl_pkg::lin_word_t         lin_i,
  output logic                       ring_ready_o,
  output logic                       result_valid_o,
  input  logic                       result_ready_i,
  output logic [opl_pkg::HUND_W-1:0] oxygen_hundredths_o
);

  opl_pkg::ring_state_e state_q, state_d;

  logic [opl_pkg::HUND_W-1:0]    ring_mem [opl_pkg::AVG_DEPTH];
  logic [opl_pkg::AVG_DEPTH-1:0] filled_q;
  logic [opl_pkg::HUND_W-1:0]    rd_data_q;
  logic                          rd_filled_q;
  logic [opl_pkg::HUND_W-1:0]    val_q;
  logic [opl_pkg::SLOT_W-1:0]    slot_q;
  logic [opl_pkg::SUM_W-1:0]     sum_q;
  logic                          out_valid_q;
  logic [opl_pkg::HUND_W-1:0]    out_data_q;

  logic                                   accept;
  logic                                   out_free;
  logic [opl_pkg::HUND_W-1:0]             old_val;
  logic [opl_pkg::SUM_W-1:0]              sum_d;
  logic [opl_pkg::SUM_W+opl_pkg::RECIP_W-1:0] mean_prod;

  assign accept   = lin_i.valid && ring_ready_o;
  assign out_free = !out_valid_q || result_ready_i;

  // Never-written entries count as zero
  assign old_val   = rd_filled_q ? rd_data_q : '0;
  assign sum_d     = sum_q - opl_pkg::SUM_W'(old_val) + opl_pkg::SUM_W'(val_q);
  assign mean_prod = sum_q * opl_pkg::DIV_RECIP;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      opl_pkg::RING_IDLE: begin
        if (lin_i.valid) state_d = opl_pkg::RING_UPDATE;
      end
      opl_pkg::RING_UPDATE: state_d = opl_pkg::RING_MEAN;
      opl_pkg::RING_MEAN: begin
        if (out_free) state_d = opl_pkg::RING_IDLE;
      end
      default: state_d = opl_pkg::RING_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ring_ready_o        = (state_q == opl_pkg::RING_IDLE);
    result_valid_o      = out_valid_q;
    oxygen_hundredths_o = out_data_q;
  end

  // Ring memory: read the slot on accept, write it back in the cycle after.
  // Items are handled one at a time, so a read never overlaps a write.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_data_q <= ring_mem[slot_q];
      val_q     <= lin_i.hundredths;
    end
    if (state_q == opl_pkg::RING_UPDATE) begin
      ring_mem[slot_q] <= val_q;
    end
  end

  // Control, fill bits, sum and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= opl_pkg::RING_IDLE;
      filled_q    <= '0;
      rd_filled_q <= 1'b0;
      slot_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rd_filled_q <= filled_q[slot_q];
      end
      if (state_q == opl_pkg::RING_UPDATE) begin
        filled_q[slot_q] <= 1'b1;
        sum_q            <= sum_d;
        slot_q           <= (slot_q == opl_pkg::SLOT_LAST) ? '0 : slot_q + 1'b1;
      end
      // Drop the word once taken, load the new mean when free
      if (state_q == opl_pkg::RING_MEAN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == opl_pkg::RING_MEAN && out_free) begin
      out_data_q <= mean_prod[opl_pkg::DIV_SHIFT +: opl_pkg::HUND_W];
    end
  end

endmodule

### rtl/opl_checker.sv
// Port-level checks for the oxygen percent linearizer, bound to the top
// level. Depends on opl_pkg.
`timescale 1ns / 1ps

module opl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [opl_pkg::HUND_W-1:0] out_data_i
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed or dropped while stalled");

  // Mean never exceeds 21 percent
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i <= opl_pkg::HUND_MAX)
    else $error("result above 2100 hundredths");

  // A sample word blocks the input for its scale and region cycles
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("input accepted again too early");

endmodule

bind oxygen_percent_linearizer_avg opl_checker u_opl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.oxygen_hundredths)
);

### bench/opl_mean_checker.sv
// Checker for the oxygen percent linearizer: watches both channels and the
// reference register port, predicts each averaged word and compares it.
// Depends on opl_pkg, opl_sample_if and opl_result_if.
`timescale 1ns / 1ps

module opl_mean_checker import opl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  opl_sample_if               sample_i,
  opl_result_if               result_i,
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // Q24 constants of the scaling and the region edges
  localparam longint Q24_SCALE  = 158005;
  localparam longint Q24_OFFSET = 9400675;
  localparam longint Q24_LOW    = 12918456;
  localparam longint Q24_TOP    = 352321536;

  logic [SAMPLE_W-1:0] reference;
  logic [HUND_W-1:0]   history [AVG_DEPTH];
  int                  next_slot;
  int                  history_total;
  logic [HUND_W-1:0]   expected_hundredths [$];
  logic [HUND_W-1:0]   linear_word;
  logic [HUND_W-1:0]   want;
  int                  mismatch_count;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Scale the sample against the reference, run the region polynomial with
  // floored Q24 products, clamp to 0..21 percent and cut to hundredths.
  function automatic logic [HUND_W-1:0] oxygen_from_sample(
      input logic [SAMPLE_W-1:0] sample, input logic [SAMPLE_W-1:0] ref_code);
    longint diff;
    longint x;
    longint y;
    longint coef [5];
    int     terms;
    diff = longint'(sample) - longint'(ref_code);
    x = diff * Q24_SCALE + Q24_OFFSET;
    terms = 0;
    if (x < Q24_LOW) begin
      coef[0] = -141415154;
      coef[1] = 196461199;
      coef[2] = -31625052;
      coef[3] = 2749786;
      terms = 4;
    end else begin
      coef[0] = 2965;
      coef[1] = -133010;
      coef[2] = 1813617;
      coef[3] = 9641866;
      coef[4] = 23907533;
      terms = 5;
    end
    if (x < 0) begin
      y = 0;
    end else if (x < Q24_TOP) begin
      y = coef[0];
      for (int i = 1; i < terms; i++) begin
        y = ((y * x) >>> 24) + coef[i];
      end
    end else begin
      y = Q24_TOP;
    end
    if (y < 0) begin
      y = 0;
    end else if (y > Q24_TOP) begin
      y = Q24_TOP;
    end
    return HUND_W'((y * 100) >>> 24);
  endfunction

  // Track the reference, predict on each accepted sample, check each result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reference = REF_RESET;
      for (int i = 0; i < AVG_DEPTH; i++) history[i] = '0;
      next_slot = 0;
      history_total = 0;
      expected_hundredths.delete();
      pending_o <= 0;
    end else begin
      // advance the history on each accepted sample word
      if (sample_i.valid && sample_i.ready) begin
        linear_word = oxygen_from_sample(sample_i.lambda_sample, reference);
        history_total = history_total - int'(history[next_slot]) + int'(linear_word);
        history[next_slot] = linear_word;
        next_slot = (next_slot + 1) % AVG_DEPTH;
        expected_hundredths.push_back(HUND_W'(history_total / AVG_DEPTH));
      end
      // compare each accepted result word with the oldest prediction
      if (result_i.valid && result_i.ready) begin
        if (expected_hundredths.size() == 0) begin
          report_mismatch($sformatf("unexpected word oxygen_hundredths=%0d",
                                    result_i.oxygen_hundredths));
        end else begin
          want = expected_hundredths.pop_front();
          if (result_i.oxygen_hundredths !== want) begin
            report_mismatch($sformatf("oxygen_hundredths got %0d, want %0d",
                                      result_i.oxygen_hundredths, want));
          end
        end
      end
      if (cfg_we_i) begin
        reference = cfg_data_i;
      end
      pending_o <= expected_hundredths.size();
    end
  end

endmodule

### bench/tb.sv
// Top of the oxygen percent linearizer bench: clock, reset, sample and
// reference stimulus, random stalls on the result side, and the verdict.
// Depends on opl_pkg, both channel interfaces, the block and opl_mean_checker.
`timescale 1ns / 1ps

module tb;
  import opl_pkg::*;

  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 205;
  localparam int CYCLE_LIMIT   = 300000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [SAMPLE_W-1:0] cfg_data;
  logic                steady;
  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;
  logic [SAMPLE_W-1:0] phase_reference;

  opl_sample_if sample_ch ();
  opl_result_if result_ch ();

  oxygen_percent_linearizer_avg i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_i   (sample_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  opl_mean_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .sample_i     (sample_ch),
    .result_i     (result_ch),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side about 15 percent of the time
  always @(posedge clk) begin
    result_ch.ready <= steady || ($urandom_range(99) >= 15);
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** oxygen_percent_linearizer_avg: FAILED **");
      $finish;
    end
  end

  // Offer one sample word, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    while (!steady && $urandom_range(99) < 15) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.lambda_sample <= sample;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted word has come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reference(input logic [SAMPLE_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Half uniform, half in the window where the polynomials apply
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] ref_code);
    int near;
    if ($urandom_range(1) == 0) begin
      return SAMPLE_W'($urandom_range(4095));
    end
    near = int'(ref_code) + int'($urandom_range(2240)) - 70;
    if (near < 0) near = 0;
    if (near > 4095) near = 4095;
    return SAMPLE_W'(near);
  endfunction

  initial begin
    sample_ch.valid         = 1'b0;
    sample_ch.lambda_sample = '0;
    result_ch.ready         = 1'b0;
    cfg_we                  = 1'b0;
    cfg_data                = '0;
    steady                  = 1'b0;
    rst_n                   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset reference: ring filling up from zero,
    // below zero, cubic, quartic and saturated regions and their edges
    send_sample(12'd0);
    send_sample(12'd1166);
    send_sample(12'd1167);
    send_sample(12'd1200);
    send_sample(12'd1226);
    send_sample(12'd1248);
    send_sample(12'd1249);
    send_sample(12'd2000);
    send_sample(12'd3396);
    send_sample(12'd3397);
    send_sample(12'd4095);
    send_sample(12'd2700);
    send_sample(12'd1500);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd3000);
    send_sample(12'd0);
    send_sample(12'd1230);
    send_sample(12'd4095);
    send_sample(12'd1180);

    // Random phases over several references, the extremes among them
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       phase_reference = 12'd0;
        1:       phase_reference = 12'd4095;
        4:       phase_reference = REF_RESET;
        default: phase_reference = SAMPLE_W'($urandom_range(4095));
      endcase
      write_reference(phase_reference);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 40) steady <= 1'b1;
        if (phase == 2 && n == 140) steady <= 1'b0;
        if (phase == 3 && n == 100) drain_results();
        send_sample(pick_sample(phase_reference));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** oxygen_percent_linearizer_avg: PASSED **");
    end else begin
      $display("** oxygen_percent_linearizer_avg: FAILED **");
    end
    $finish;
  end

endmodule
